// ===== sv/life_generation_row_step_core_macros.svh =====
// assertion macros for the life row step core
`ifndef LIFE_GENERATION_ROW_STEP_CORE_MACROS_SVH
`define LIFE_GENERATION_ROW_STEP_CORE_MACROS_SVH

// condition that holds at every clock edge out of reset
`define LGRS_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// same-cycle implication
`define LGRS_ASSERT_IMP(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define LGRS_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== sv/lgrs_pkg.sv =====
// shared constants for the life row step core
package lgrs_pkg;

    localparam int MAX_COLS_DEF = 64;   // default grid width
    localparam int DATA_W       = 64;   // stream word width
    localparam int CFG_W        = 7;    // width register
    localparam int FIFO_DEPTH   = 4;    // result queue depth
    localparam int NBR_W        = 4;    // neighbour count width

    localparam logic [CFG_W-1:0] COLS_RESET    = 7'd64;
    localparam logic [NBR_W-1:0] BIRTH_COUNT   = 4'd3;
    localparam logic [NBR_W-1:0] SURVIVE_COUNT = 4'd2;

endpackage

// ===== sv/lgrs_lane.sv =====
// one cell of the b3/s23 rule
module lgrs_lane
    import lgrs_pkg::*;
(
    input  logic [2:0] i_up,
    input  logic [2:0] i_mid,
    input  logic [2:0] i_dn,
    output logic       o_next
);

    logic [NBR_W-1:0] nbr;

    always_comb begin
        nbr = NBR_W'(i_up[0]) + NBR_W'(i_up[1]) + NBR_W'(i_up[2])
            + NBR_W'(i_mid[0]) + NBR_W'(i_mid[2])
            + NBR_W'(i_dn[0]) + NBR_W'(i_dn[1]) + NBR_W'(i_dn[2]);
        o_next = (nbr == BIRTH_COUNT) || (i_mid[1] && (nbr == SURVIVE_COUNT));
    end

endmodule

// ===== sv/lgrs_row.sv =====
// row of parallel cell lanes with edge padding and width mask
module lgrs_row
    import lgrs_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF
) (
    input  logic [MAX_COLS-1:0] i_up,
    input  logic [MAX_COLS-1:0] i_mid,
    input  logic [MAX_COLS-1:0] i_dn,
    input  logic [MAX_COLS-1:0] i_mask,
    output logic [MAX_COLS-1:0] o_next
);

    logic [MAX_COLS+1:0] up_x;
    logic [MAX_COLS+1:0] mid_x;
    logic [MAX_COLS+1:0] dn_x;
    logic [MAX_COLS-1:0] lane_out;

    // dead cells left of column 0 and right of the last column
    assign up_x  = {1'b0, i_up, 1'b0};
    assign mid_x = {1'b0, i_mid, 1'b0};
    assign dn_x  = {1'b0, i_dn, 1'b0};

    for (genvar j = 0; j < MAX_COLS; j++) begin : g_lane
        lgrs_lane u_lane (
            .i_up  (up_x[j+2:j]),
            .i_mid (mid_x[j+2:j]),
            .i_dn  (dn_x[j+2:j]),
            .o_next(lane_out[j])
        );
    end

    assign o_next = lane_out & i_mask;

endmodule

// ===== sv/life_generation_row_step_core.sv =====
// life b3/s23 row step core: one generation over a streamed grid
// results: each accepted input word writes its results into the result queue, which is read out from its head
// throughput: one input word per cycle while the result queue has two free slots;
//   the master side moves one result word per cycle while m_axis_tready is high, and
//   a bottom row that follows a held row pushes two results
// reset: synchronous active low; width register returns to 64, queue empties, no row held
module life_generation_row_step_core
    import lgrs_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // width register write channel
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_W-1:0]  i_cfg_data,     // cols_in_use
    // row input stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [DATA_W-1:0] s_axis_tdata,   // row_cells
    input  logic              s_axis_tuser,   // first_row
    input  logic              s_axis_tlast,   // last_row
    // next-generation output stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [DATA_W-1:0] m_axis_tdata,   // next_cells
    output logic              m_axis_tlast    // final_row
);

`include "life_generation_row_step_core_macros.svh"

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    // width register
    logic [CFG_W-1:0]    r_cols;
    logic [CFG_W-1:0]    width;
    logic [MAX_COLS-1:0] mask;

    // row window: the row above the held one and the held row itself
    logic [MAX_COLS-1:0] r_above;
    logic [MAX_COLS-1:0] r_held;
    logic                r_pending;

    // result queue
    logic [MAX_COLS-1:0] r_q_cells [FIFO_DEPTH];
    logic                r_q_last  [FIFO_DEPTH];
    logic [PTR_W-1:0]    r_wr_ptr;
    logic [PTR_W-1:0]    r_rd_ptr;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;

    logic                in_acc;
    logic                out_acc;
    logic [MAX_COLS-1:0] in_row;
    logic [MAX_COLS-1:0] above_m;
    logic [MAX_COLS-1:0] held_m;
    logic                emit_held;
    logic [MAX_COLS-1:0] up_new;
    logic [MAX_COLS-1:0] next_held;
    logic [MAX_COLS-1:0] next_new;
    logic [MAX_COLS-1:0] slot0_cells;
    logic                slot0_last;
    logic [1:0]          n_push;

    // width in force: zero acts as one, anything past the lane count is clamped
    always_comb begin
        if (r_cols == '0) begin
            width = CFG_W'(1);
        end else if (r_cols > CFG_W'(MAX_COLS)) begin
            width = CFG_W'(MAX_COLS);
        end else begin
            width = r_cols;
        end
        for (int j = 0; j < MAX_COLS; j++) begin
            mask[j] = CFG_W'(j) < width;
        end
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= COLS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cols <= i_cfg_data;
        end
    end

    // stored rows are re-masked with the width in force now
    assign in_row  = s_axis_tdata[MAX_COLS-1:0] & mask;
    assign above_m = r_above & mask;
    assign held_m  = r_held & mask;

    // a held row is owed its result unless a new grid begins
    assign emit_held = r_pending && !s_axis_tuser;
    assign up_new    = emit_held ? held_m : '0;

    // held row: above, held, new row below
    lgrs_row #(.MAX_COLS(MAX_COLS)) u_row_held (
        .i_up  (above_m),
        .i_mid (held_m),
        .i_dn  (in_row),
        .i_mask(mask),
        .o_next(next_held)
    );

    // new row as the bottom row: dead row below
    lgrs_row #(.MAX_COLS(MAX_COLS)) u_row_new (
        .i_up  (up_new),
        .i_mid (in_row),
        .i_dn  ('0),
        .i_mask(mask),
        .o_next(next_new)
    );

    // accept while two queue slots are free, so a word can land every cycle
    assign s_axis_tready = r_count <= CNT_W'(FIFO_DEPTH - 2);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_acc       = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
        end else if (in_acc) begin
            r_pending <= !s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            if (s_axis_tlast) begin
                r_above <= '0;
                r_held  <= '0;
            end else begin
                r_above <= up_new;
                r_held  <= in_row;
            end
        end
    end

    // merge: the held-row result goes first, the bottom-row result after it
    always_comb begin
        slot0_cells = emit_held ? next_held : next_new;
        slot0_last  = !emit_held;
        n_push      = 2'(emit_held) + 2'(s_axis_tlast);
        if (!in_acc) begin
            n_push = 2'd0;
        end
        n_count = r_count + CNT_W'(n_push) - CNT_W'(out_acc);
    end

    always_ff @(posedge i_clk) begin
        if (n_push != 2'd0) begin
            r_q_cells[r_wr_ptr] <= slot0_cells;
            r_q_last[r_wr_ptr]  <= slot0_last;
        end
        if (n_push == 2'd2) begin
            r_q_cells[r_wr_ptr + PTR_W'(1)] <= next_new;
            r_q_last[r_wr_ptr + PTR_W'(1)]  <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PTR_W'(n_push);
            if (out_acc) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    assign m_axis_tvalid = r_count != '0;
    assign m_axis_tdata  = DATA_W'(r_q_cells[r_rd_ptr]);
    assign m_axis_tlast  = r_q_last[r_rd_ptr];

    `LGRS_ASSERT_ALWAYS(a_count_bound, r_count <= CNT_W'(FIFO_DEPTH), "result queue overflow")
    `LGRS_ASSERT_NEXT(a_last_clears, in_acc && s_axis_tlast, !r_pending, "row still held after bottom row")
    `LGRS_ASSERT_NEXT(a_pop_only, out_acc && !in_acc, r_count == $past(r_count) - CNT_W'(1), "queue count slip on pop")
    `LGRS_ASSERT_NEXT(a_two_results, in_acc && emit_held && s_axis_tlast && !out_acc, r_count == $past(r_count) + CNT_W'(2), "bottom row lost a result")

endmodule
